@@ rtl/core/utf8esc_pkg.sv @@
// Package with the job types and character helpers of the UTF-8 escape formatter.
package utf8esc_pkg;

	localparam int unsigned CpW  = 21;
	localparam int unsigned LenW = 4;

	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChU      = 8'h75;
	localparam logic [7:0] ChN      = 8'h6E;
	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChLbrace = 8'h7B;
	localparam logic [7:0] ChRbrace = 8'h7D;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChLowA   = 8'h61;

	// What one accepted byte turns into on the output side.
	typedef enum logic [1:0] {
		JOB_SINGLE,
		JOB_PAIR,
		JOB_HEX
	} job_kind_t;

	typedef struct packed {
		job_kind_t        kind;
		logic [7:0]       ch;
		logic [CpW-1:0]   value;
		logic [2:0]       ndig;
		logic [LenW-1:0]  len;
	} job_t;

	// Lower-case hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			hex_char = ChZero + {4'd0, nib};
		end else begin
			hex_char = ChLowA + {4'd0, nib} - 8'd10;
		end
	endfunction

	// Number of hex digits with no leading zeros; zero itself takes one digit.
	function automatic logic [2:0] digit_count(input logic [CpW-1:0] v);
		if (v[20]) begin
			digit_count = 3'd6;
		end else if (v[19:16] != 4'd0) begin
			digit_count = 3'd5;
		end else if (v[15:12] != 4'd0) begin
			digit_count = 3'd4;
		end else if (v[11:8] != 4'd0) begin
			digit_count = 3'd3;
		end else if (v[7:4] != 4'd0) begin
			digit_count = 3'd2;
		end else begin
			digit_count = 3'd1;
		end
	endfunction

	// Nibble of the code point at the given position, counted from the low end.
	function automatic logic [3:0] nibble_at(input logic [CpW-1:0] v, input logic [2:0] pos);
		case (pos)
			3'd0:    nibble_at = v[3:0];
			3'd1:    nibble_at = v[7:4];
			3'd2:    nibble_at = v[11:8];
			3'd3:    nibble_at = v[15:12];
			3'd4:    nibble_at = v[19:16];
			3'd5:    nibble_at = {3'd0, v[20]};
			default: nibble_at = 4'd0;
		endcase
	endfunction

endpackage

@@ rtl/core/utf8_escape_formatter.sv @@
// Top level of the UTF-8 escape formatter: byte decoder, job register and character emitter.
//
// Each accepted byte is decoded combinationally into a job held in the job register, and the
// emitter sends that job's characters one per cycle through the output register while the
// output is not stalled. A new byte is taken in every cycle while the output keeps up and each
// byte gives at most one character. A byte that gives more holds the job register until its
// last character is sent: two characters for the escapes of newline, backslash and double
// quote, and 4 + d for a \u{...} escape with d hex digits, so up to 10 for the largest code
// point. An end-of-string transfer drops any partial UTF-8 sequence and gives no character.
// last_char marks the final character of each input byte.
module utf8_escape_formatter
	import utf8esc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_char
);

	// Decoder state and job stage.
	logic [CpW-1:0]  pend_q;
	logic [1:0]      rem_q;
	logic            job_vld_s1;
	job_t            job_s1;
	logic [LenW-1:0] idx_q;

	// Output register.
	logic            out_vld_q;
	logic [7:0]      out_char_q;
	logic            out_last_q;

	// Decode results.
	logic [CpW-1:0]  nxt_pend;
	logic [1:0]      nxt_rem;
	logic            dec_has_job;
	job_t            dec_job;
	logic [CpW-1:0]  cont_value;
	logic [CpW-1:0]  hex_value;
	logic [2:0]      hex_ndig;

	// Emitter signals.
	logic            out_free;
	logic            is_last;
	logic            job_done;
	logic            in_xfer;
	logic [7:0]      cur_char;
	logic [LenW-1:0] pos_full;

	assign cont_value = {pend_q[CpW-7:0], in_byte[5:0]};

	// Decode one byte against the pending sequence state.
	always_comb begin
		nxt_pend    = '0;
		nxt_rem     = 2'd0;
		dec_has_job = 1'b0;
		hex_value   = {13'd0, in_byte};
		dec_job     = '{kind: JOB_SINGLE, ch: in_byte, value: '0, ndig: 3'd1, len: 4'd1};
		if (end_of_string) begin
			dec_has_job = 1'b0;
		end else if (rem_q != 2'd0 && in_byte[7:6] == 2'b10) begin
			// Continuation byte of the pending sequence.
			nxt_rem = rem_q - 2'd1;
			if (rem_q == 2'd1) begin
				dec_has_job = 1'b1;
				dec_job.kind = JOB_HEX;
				hex_value = cont_value;
			end else begin
				nxt_pend = cont_value;
			end
		end else begin
			// Fresh byte; any pending sequence is abandoned.
			case (in_byte) inside
				8'h0A: begin
					dec_has_job = 1'b1;
					dec_job.kind = JOB_PAIR;
					dec_job.ch = ChN;
				end
				8'h5C: begin
					dec_has_job = 1'b1;
					dec_job.kind = JOB_PAIR;
					dec_job.ch = ChBslash;
				end
				8'h22: begin
					dec_has_job = 1'b1;
					dec_job.kind = JOB_PAIR;
					dec_job.ch = ChQuote;
				end
				[8'h00:8'h1F]: begin
					dec_has_job = 1'b1;
					dec_job.kind = JOB_HEX;
				end
				[8'h20:8'h7F]: begin
					dec_has_job = 1'b1;
				end
				[8'hC0:8'hDF]: begin
					nxt_pend = {16'd0, in_byte[4:0]};
					nxt_rem  = 2'd1;
				end
				[8'hE0:8'hEF]: begin
					nxt_pend = {17'd0, in_byte[3:0]};
					nxt_rem  = 2'd2;
				end
				[8'hF0:8'hF7]: begin
					nxt_pend = {18'd0, in_byte[2:0]};
					nxt_rem  = 2'd3;
				end
				default: begin
					dec_has_job = 1'b0;
				end
			endcase
		end
		hex_ndig = digit_count(hex_value);
		if (dec_job.kind == JOB_HEX) begin
			dec_job.value = hex_value;
			dec_job.ndig  = hex_ndig;
			dec_job.len   = {1'b0, hex_ndig} + 4'd4;
		end else if (dec_job.kind == JOB_PAIR) begin
			dec_job.len = 4'd2;
		end
	end

	// Character at the current index of the held job.
	assign pos_full = {1'b0, job_s1.ndig} + 4'd2 - idx_q;

	always_comb begin
		cur_char = job_s1.ch;
		case (job_s1.kind)
			JOB_SINGLE: cur_char = job_s1.ch;
			JOB_PAIR: begin
				cur_char = (idx_q == 4'd0) ? ChBslash : job_s1.ch;
			end
			JOB_HEX: begin
				if (idx_q == 4'd0) begin
					cur_char = ChBslash;
				end else if (idx_q == 4'd1) begin
					cur_char = ChU;
				end else if (idx_q == 4'd2) begin
					cur_char = ChLbrace;
				end else if (is_last) begin
					cur_char = ChRbrace;
				end else begin
					cur_char = hex_char(nibble_at(job_s1.value, pos_full[2:0]));
				end
			end
			default: cur_char = job_s1.ch;
		endcase
	end

	// Handshake between the job stage and the output register.
	assign out_free = !out_vld_q || !out_stall;
	assign is_last  = (idx_q == job_s1.len - 4'd1);
	assign job_done = job_vld_s1 && out_free && is_last;
	assign in_stall = job_vld_s1 && !job_done;
	assign in_xfer  = in_valid && !in_stall;

	// Decoder state, job register and character index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			rem_q      <= 2'd0;
			job_vld_s1 <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (in_xfer) begin
				pend_q     <= nxt_pend;
				rem_q      <= nxt_rem;
				job_vld_s1 <= dec_has_job;
				idx_q      <= '0;
			end else if (job_done) begin
				job_vld_s1 <= 1'b0;
				idx_q      <= '0;
			end else if (job_vld_s1 && out_free) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			job_s1 <= dec_job;
		end
	end

	// Output register loads a character whenever it is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= job_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_char_q <= cur_char;
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_vld_q;
	assign out_char  = out_char_q;
	assign last_char = out_last_q;

endmodule

@@ dv/utf8_escape_formatter_test.sv @@
// Self-checking testbench for the UTF-8 escape formatter with randomized stalls on both sides.
module utf8_escape_formatter_test
	import utf8esc_pkg::*;
();

	localparam int unsigned RANDOM_ITEMS   = 200;
	localparam int unsigned HOLD_AT        = 60;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES  = 24;
	localparam int unsigned REPORT_LIMIT   = 10;

	localparam logic [0:15][7:0] HEX_DIGITS = "0123456789abcdef";

	// One raw byte waiting to be sent, with a request to drain the output first.
	typedef struct packed {
		logic [7:0] data;
		logic       eos;
		logic       drain;
	} raw_byte_t;

	// One character of escaped text as the block should send it.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       last_char;

	raw_byte_t  raw_bytes[$];
	text_char_t escaped_chars[$];
	logic [7:0] spelled[$];

	// Decoder state of the predictor.
	logic [20:0] cp_accum = '0;
	logic [1:0]  cont_left = '0;

	logic        in_taken = 1'b0;
	logic        drain_next = 1'b0;
	int unsigned queued = 0;
	int unsigned inputs_taken = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_wait = 0;
	int unsigned send_burst = 0;
	int unsigned recv_wait = 0;
	int unsigned recv_burst = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	utf8_escape_formatter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_char      (out_char),
		.last_char     (last_char)
	);

	// Clock, and a reset released on a falling clock edge.
	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		else if (roll < 85) return $urandom_range(1, 2);
		else if (roll < 97) return $urandom_range(3, 8);
		else return $urandom_range(20, 50);
	endfunction

	// Append a \u{...} escape with lower-case digits and no leading zeros.
	task automatic spell_hex(input logic [20:0] v);
		logic [23:0] wide;
		int          top;
		wide = {3'b000, v};
		top = 5;
		while (top > 0 && wide[top*4 +: 4] == 4'h0) top--;
		spelled.push_back(ChBslash);
		spelled.push_back(ChU);
		spelled.push_back(ChLbrace);
		for (int k = top; k >= 0; k--) spelled.push_back(HEX_DIGITS[wide[k*4 +: 4]]);
		spelled.push_back(ChRbrace);
	endtask

	// Predict the escaped characters that one accepted transfer causes.
	task automatic escape_byte(input logic [7:0] b, input logic eos);
		logic [20:0] merged;
		spelled.delete();
		if (eos) begin
			cp_accum = '0;
			cont_left = '0;
		end else if (cont_left != 2'd0 && b[7:6] == 2'b10) begin
			merged = {cp_accum[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				spell_hex(merged);
				cp_accum = '0;
			end else begin
				cp_accum = merged;
			end
		end else begin
			// A byte that breaks a pending sequence is handled as a fresh byte.
			cp_accum = '0;
			cont_left = '0;
			if (b == 8'h0A) begin
				spelled.push_back(ChBslash);
				spelled.push_back(ChN);
			end else if (b == ChBslash) begin
				spelled.push_back(ChBslash);
				spelled.push_back(ChBslash);
			end else if (b == ChQuote) begin
				spelled.push_back(ChBslash);
				spelled.push_back(ChQuote);
			end else if (b < 8'h20) begin
				spell_hex({13'd0, b});
			end else if (b < 8'h80) begin
				spelled.push_back(b);
			end else if (b < 8'hC0) begin
				// Stray continuation bytes are dropped.
			end else if (b < 8'hE0) begin
				cp_accum = {16'd0, b[4:0]};
				cont_left = 2'd1;
			end else if (b < 8'hF0) begin
				cp_accum = {17'd0, b[3:0]};
				cont_left = 2'd2;
			end else if (b < 8'hF8) begin
				cp_accum = {18'd0, b[2:0]};
				cont_left = 2'd3;
			end
		end
		foreach (spelled[i]) escaped_chars.push_back({spelled[i], i == spelled.size() - 1});
	endtask

	task automatic queue_byte(input logic [7:0] data, input logic eos);
		raw_bytes.push_back({data, eos, drain_next});
		drain_next = 1'b0;
		queued++;
	endtask

	// Sender: offers the next byte once the previous transfer is done.
	always @(negedge clk) begin : drive_bytes
		raw_byte_t nxt;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (send_wait != 0) begin
					in_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (raw_bytes.size() == 0 ||
						(raw_bytes[0].drain && escaped_chars.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					nxt = raw_bytes.pop_front();
					in_byte <= nxt.data;
					end_of_string <= nxt.eos;
					in_valid <= 1'b1;
					if (send_burst != 0) begin
						send_burst <= send_burst - 1;
					end else if ($urandom_range(0, 19) == 0) begin
						send_burst <= $urandom_range(20, 40);
					end else begin
						send_wait <= idle_len();
					end
				end
			end
		end
	end

	// Receiver: random stalls, calm stretches, and one long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && inputs_taken >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (recv_wait != 0) begin
				out_stall <= 1'b1;
				recv_wait <= recv_wait - 1;
			end else begin
				out_stall <= 1'b0;
				if (recv_burst != 0) begin
					recv_burst <= recv_burst - 1;
				end else if ($urandom_range(0, 19) == 0) begin
					recv_burst <= $urandom_range(20, 60);
				end else begin
					recv_wait <= idle_len();
				end
			end
		end
	end

	// Monitor: checks each output transfer, predicts each input transfer, and
	// runs the watchdog.
	always @(posedge clk) begin : watch_ports
		text_char_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (escaped_chars.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("unexpected character: got %h last %b", out_char, last_char);
					mismatches++;
				end else begin
					want = escaped_chars.pop_front();
					if (want.ch !== out_char || want.last !== last_char) begin
						if (mismatches < REPORT_LIMIT)
							$display("character mismatch: expected %h last %b, got %h last %b",
								want.ch, want.last, out_char, last_char);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				escape_byte(in_byte, end_of_string);
				inputs_taken <= inputs_taken + 1;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[utf8_escape_formatter] ERROR");
				$finish;
			end
		end
	end

	// Stimulus: directed cases first, then random strings.
	initial begin
		int unsigned roll;
		int unsigned seq_len;
		int unsigned given;
		logic [7:0]  lead;
		logic [7:0]  tail;

		// Control bytes, the three short escapes, printable edges, dropped bytes.
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h0A, 1'b0);
		queue_byte(8'h5C, 1'b0);
		queue_byte(8'h22, 1'b0);
		queue_byte(8'h1F, 1'b0);
		queue_byte(8'h20, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hF8, 1'b0);
		// Well-formed two, three and four byte sequences, the last one the largest.
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'hA9, 1'b0);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b0);
		queue_byte(8'hAC, 1'b0);
		queue_byte(8'hF7, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		// A bad continuation abandons the sequence and is printed itself.
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h41, 1'b0);
		// End of string drops a partial sequence; the next continuation is stray.
		queue_byte(8'hC0, 1'b0);
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h00, 1'b1);

		drain_next = 1'b1;
		while (queued < 25 + RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 29) == 0) drain_next = 1'b1;
			if (roll < 35) begin
				queue_byte(8'($urandom_range(0, 127)), 1'b0);
			end else if (roll < 82) begin
				seq_len = $urandom_range(1, 3);
				case (seq_len)
					1: lead = 8'hC0 | 8'($urandom_range(0, 31));
					2: lead = 8'hE0 | 8'($urandom_range(0, 15));
					default: lead = 8'hF0 | 8'($urandom_range(0, 7));
				endcase
				queue_byte(lead, 1'b0);
				// Most sequences complete; some are cut short by a new byte or an end.
				given = (roll < 70) ? seq_len : $urandom_range(0, seq_len - 1);
				repeat (given) queue_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
				if (given < seq_len) begin
					tail = 8'($urandom_range(0, 255));
					if (tail[7:6] == 2'b10) tail[6] = 1'b1;
					queue_byte(tail, $urandom_range(0, 2) == 0);
				end
			end else if (roll < 90) begin
				queue_byte(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				queue_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		end

		while (raw_bytes.size() != 0 || in_valid) @(posedge clk);
		while (escaped_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && escaped_chars.size() == 0) begin
			$display("[utf8_escape_formatter] OK");
		end else begin
			$display("[utf8_escape_formatter] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/utf8esc_pkg.sv
rtl/core/utf8_escape_formatter.sv
dv/utf8_escape_formatter_test.sv
